// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL: a held property and a forbidden condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/u8d_pkg.sv -----
// Types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_TUSER_W = 2;

    typedef logic [CP_W-1:0]  t_code_point;
    typedef logic [LEN_W-1:0] t_seq_len;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_REPLACED = 2'd1;
    localparam t_status ST_INVALID  = 2'd2;

    localparam t_code_point CP_SPACE = 31'h20;
    localparam t_code_point CP_ZERO  = 31'h0;

    localparam t_seq_len LEN_NONE = 3'd0;
    localparam t_seq_len LEN_1    = 3'd1;
    localparam t_seq_len LEN_2    = 3'd2;
    localparam t_seq_len LEN_3    = 3'd3;
    localparam t_seq_len LEN_4    = 3'd4;
    localparam t_seq_len LEN_5    = 3'd5;
    localparam t_seq_len LEN_6    = 3'd6;

endpackage

`default_nettype wire

// ----- rtl/core/utf8_stream_decoder.sv -----
// UTF-8 stream decoder: bytes in, code points out, a byte per unstalled cycle.
//
// Slave channel s_axis carries one raw byte per transfer in tdata[7:0].
// Master channel m_axis carries one decoded character per transfer:
// tdata holds the code point and the sequence length, tuser the status
// (ok, stray continuation replaced by a space, invalid lead byte).
// Sequences of one to six bytes are decoded; continuation bytes give their
// low six bits unchecked. Only the byte that ends a sequence, a stray
// continuation or an invalid lead produces a result; other bytes produce none.
// Path: a byte taken is registered in the input register, decoded from there
// into the result register, and shown on m_axis from the result register.
// Throughput: one byte per cycle unless m_axis stalls, set by the single
// decode step between the input register and the result register.
// Reset clears both valid flags and the sequence state, so the decoder
// waits for a lead byte. When the receiver stalls, the result register
// holds, the input register fills, and s_axis_tready falls after that.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire  i_clk,
    input  wire  i_rst_n,
    // tdata: in_byte [7:0]
    input  wire  [u8d_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire  s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: code_point [30:0], seq_length [33:31], zero pad [39:34]
    output logic [u8d_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status [1:0]
    output logic [u8d_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic m_axis_tvalid,
    input  wire  m_axis_tready
);
    import u8d_pkg::*;

    `include "assert_macros.svh"

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_code_point r_partial;
    t_seq_len    r_left;
    t_seq_len    r_total;
    t_code_point n_partial;
    t_seq_len    n_left;
    t_seq_len    n_total;

    logic        r_out_valid;
    t_code_point r_out_cp;
    t_seq_len    r_out_len;
    t_status     r_out_st;

    logic        w_adv;
    logic        w_fire;
    logic        w_emit;
    t_code_point w_cp;
    t_seq_len    w_len;
    t_status     w_st;
    t_code_point w_shifted;

    // The result register frees when empty or when its transfer completes
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    assign w_shifted = {r_partial[CP_W-7:0], r_in_byte[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_total   = r_total;
        w_emit    = 1'b0;
        w_cp      = CP_ZERO;
        w_len     = LEN_NONE;
        w_st      = ST_OK;
        if (r_left != LEN_NONE) begin
            n_left = r_left - 3'd1;
            if (r_left == LEN_1) begin
                // last continuation: deliver and go back to awaiting a lead
                w_emit    = 1'b1;
                w_cp      = w_shifted;
                w_len     = r_total;
                n_partial = CP_ZERO;
                n_total   = LEN_NONE;
            end else begin
                n_partial = w_shifted;
            end
        end else if (!r_in_byte[7]) begin
            w_emit = 1'b1;
            w_cp   = {{(CP_W-BYTE_W){1'b0}}, r_in_byte};
            w_len  = LEN_1;
        end else if (!r_in_byte[6]) begin
            w_emit = 1'b1;
            w_cp   = CP_SPACE;
            w_len  = LEN_1;
            w_st   = ST_REPLACED;
        end else if (!r_in_byte[5]) begin
            n_partial = {{(CP_W-5){1'b0}}, r_in_byte[4:0]};
            n_total   = LEN_2;
            n_left    = LEN_1;
        end else if (!r_in_byte[4]) begin
            n_partial = {{(CP_W-4){1'b0}}, r_in_byte[3:0]};
            n_total   = LEN_3;
            n_left    = LEN_2;
        end else if (!r_in_byte[3]) begin
            n_partial = {{(CP_W-3){1'b0}}, r_in_byte[2:0]};
            n_total   = LEN_4;
            n_left    = LEN_3;
        end else if (!r_in_byte[2]) begin
            n_partial = {{(CP_W-2){1'b0}}, r_in_byte[1:0]};
            n_total   = LEN_5;
            n_left    = LEN_4;
        end else if (!r_in_byte[1]) begin
            n_partial = {{(CP_W-1){1'b0}}, r_in_byte[0]};
            n_total   = LEN_6;
            n_left    = LEN_5;
        end else begin
            w_emit = 1'b1;
            w_st   = ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= CP_ZERO;
            r_left    <= LEN_NONE;
            r_total   <= LEN_NONE;
        end else if (w_fire) begin
            r_partial <= n_partial;
            r_left    <= n_left;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_emit;
        end
    end

    // hold the payload until its transfer completes
    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_cp  <= w_cp;
            r_out_len <= w_len;
            r_out_st  <= w_st;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W-LEN_W){1'b0}}, r_out_len, r_out_cp};
    assign m_axis_tuser  = r_out_st;

    `ASSERT_NEVER(a_left_range, i_clk, i_rst_n, r_left > LEN_5)
    `ASSERT_PROP(a_idle_no_total, i_clk, i_rst_n,
        (r_left == LEN_NONE) |-> (r_total == LEN_NONE))
    `ASSERT_PROP(a_total_above_left, i_clk, i_rst_n,
        (r_left != LEN_NONE) |-> (r_total > r_left))
    `ASSERT_PROP(a_invalid_payload, i_clk, i_rst_n,
        (r_out_valid && r_out_st == ST_INVALID) |->
            (r_out_len == LEN_NONE && r_out_cp == CP_ZERO))
    `ASSERT_PROP(a_stall_holds_input, i_clk, i_rst_n,
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))

endmodule

`default_nettype wire

// ----- dv/utf8_stream_decoder_test.sv -----
// Self-checking testbench for the UTF-8 stream decoder: byte stream in, predicted characters out.
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
    import u8d_pkg::*;

    localparam int unsigned BYTE_GOAL    = 1400;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_code_point cp;
        t_seq_len    len;
        t_status     st;
    } t_decoded_char;

    // Tracks the decoder's sequence state and holds the characters still owed.
    class char_scoreboard;
        t_code_point     partial_cp;
        t_seq_len        conts_left;
        t_seq_len        seq_len;
        t_decoded_char   char_q[$];
        int unsigned     errors;
        int unsigned     bytes_seen;
        int unsigned     chars_seen;
        int unsigned     status_count[3];

        function new();
            partial_cp = CP_ZERO;
            conts_left = LEN_NONE;
            seq_len    = LEN_NONE;
            errors     = 0;
            bytes_seen = 0;
            chars_seen = 0;
            status_count = '{0, 0, 0};
        endfunction

        function int unsigned pending();
            return char_q.size();
        endfunction

        function void queue_char(t_code_point cp, t_seq_len len, t_status st);
            t_decoded_char c;
            c.cp = cp;
            c.len = len;
            c.st = st;
            char_q.push_back(c);
        endfunction

        function void open_seq(t_code_point lead_bits, t_seq_len len);
            partial_cp = lead_bits;
            seq_len    = len;
            conts_left = len - LEN_1;
        endfunction

        function void note_byte(logic [7:0] b);
            bytes_seen++;
            // Inside a sequence every byte is taken as a continuation, top bits ignored
            if (conts_left != LEN_NONE) begin
                partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                conts_left = conts_left - LEN_1;
                if (conts_left == LEN_NONE) begin
                    queue_char(partial_cp, seq_len, ST_OK);
                    partial_cp = CP_ZERO;
                    seq_len    = LEN_NONE;
                end
                return;
            end
            if (b < 8'h80)
                queue_char(t_code_point'(b), LEN_1, ST_OK);
            else if (b < 8'hC0)
                queue_char(CP_SPACE, LEN_1, ST_REPLACED);
            else if (b < 8'hE0)
                open_seq(t_code_point'(b[4:0]), LEN_2);
            else if (b < 8'hF0)
                open_seq(t_code_point'(b[3:0]), LEN_3);
            else if (b < 8'hF8)
                open_seq(t_code_point'(b[2:0]), LEN_4);
            else if (b < 8'hFC)
                open_seq(t_code_point'(b[1:0]), LEN_5);
            else if (b < 8'hFE)
                open_seq(t_code_point'(b[0]), LEN_6);
            else
                queue_char(CP_ZERO, LEN_NONE, ST_INVALID);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_char(t_code_point cp, t_seq_len len, t_status st);
            t_decoded_char e;
            chars_seen++;
            if (st <= ST_INVALID)
                status_count[st]++;
            if (char_q.size() == 0) begin
                report($sformatf("char with nothing owed: cp=%h len=%0d st=%0d", cp, len, st));
                return;
            end
            e = char_q.pop_front();
            if (cp !== e.cp)
                report($sformatf("code point %h, predicted %h", cp, e.cp));
            if (len !== e.len)
                report($sformatf("length %0d, predicted %0d", len, e.len));
            if (st !== e.st)
                report($sformatf("status %0d, predicted %0d", st, e.st));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // in_byte [7:0]
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // code_point [30:0], seq_length [33:31], pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // status [1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;

    char_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    burst_left;
    bit             hold_request;

    utf8_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles without finishing", cycle_count);
            $display("utf8_stream_decoder_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata[CP_W-1:0], m_axis_tdata[CP_W+LEN_W-1:CP_W],
                          m_axis_tuser[ST_W-1:0]);
    end

    // Receiver: stall in segments of varying density, or hold off entirely on request
    initial begin
        int unsigned seg_left;
        int unsigned mode;
        seg_left = 0;
        mode = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = seg_left[0];
                endcase
            end
        end
    end

    task automatic idle(input int unsigned n);
        if (n == 0)
            return;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offer one byte and hold it until the transfer; gaps fall between bursts
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tdata = b;
        s_axis_tvalid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready)
                break;
        end
        sb.note_byte(b);
    endtask

    task automatic send_cont();
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte({2'b10, 6'($urandom_range(0, 63))});
    endtask

    task automatic send_seq(input logic [7:0] lead, input int unsigned n_cont);
        send_byte(lead);
        repeat (n_cont) send_cont();
    endtask

    task automatic send_random_char();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_byte(8'($urandom_range(0, 127)));
        else if (pick < 45)
            send_seq({3'b110, 5'($urandom_range(0, 31))}, 1);
        else if (pick < 55)
            send_seq({4'b1110, 4'($urandom_range(0, 15))}, 2);
        else if (pick < 63)
            send_seq({5'b11110, 3'($urandom_range(0, 7))}, 3);
        else if (pick < 70)
            send_seq({6'b111110, 2'($urandom_range(0, 3))}, 4);
        else if (pick < 77)
            send_seq({7'b1111110, 1'($urandom_range(0, 1))}, 5);
        else if (pick < 85)
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        else if (pick < 89)
            send_byte(8'($urandom_range(8'hFE, 8'hFF)));
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_chars();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] directed[$];
        bit held;
        bit drained;
        sb = new();
        cycle_count = 0;
        burst_left = 0;
        hold_request = 1'b0;
        held = 1'b0;
        drained = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ASCII ends, stray continuations, invalid leads, then one sequence per length:
        // an overlong pair, a triple with unchecked non-continuation bytes, the largest
        // four-byte form, a five-byte run of odd bytes and the top six-byte code point
        directed = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
                     8'hC0, 8'h80,
                     8'hE8, 8'h41, 8'hFF,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hF8, 8'hFF, 8'hFE, 8'hC0, 8'h00,
                     8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        foreach (directed[i])
            send_byte(directed[i]);
        wait_for_chars();

        while (sb.bytes_seen < BYTE_GOAL) begin
            if (!held && sb.bytes_seen > 500) begin
                held = 1'b1;
                hold_request = 1'b1;
            end
            if (!drained && sb.bytes_seen > 1000) begin
                drained = 1'b1;
                wait_for_chars();
            end
            send_random_char();
        end

        wait_for_chars();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted chars never came out", sb.pending()));

        $display("covered %0d bytes in all lead classes, stray and unchecked continuations",
                 sb.bytes_seen);
        $display("checked %0d chars: %0d ok, %0d replaced, %0d invalid; %0d mismatches",
                 sb.chars_seen, sb.status_count[ST_OK], sb.status_count[ST_REPLACED],
                 sb.status_count[ST_INVALID], sb.errors);
        if (sb.errors == 0)
            $display("utf8_stream_decoder_test OK");
        else
            $display("utf8_stream_decoder_test NOT OK");
        $finish;
    end

endmodule
